>>> design/deq_pkg.sv
// shared types and constants for the double-ended queue unit
package deq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_LIST
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic                load_req;
    logic                commit_push;
    logic                commit_pop;
    logic                rd_pop;
    logic                rd_first;
    logic                rd_next;
    logic                out_load;
    logic                out_from_mem;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             empty;
    logic             full;
    logic             list_last;
    logic             out_free;
  } deq_stat_t;

endpackage

>>> design/deq_if.sv
// request and result channel interfaces
interface deq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_value;
  logic               last;

  modport source (output valid, output status, output out_value, output last, input ready);
  modport sink   (input valid, input status, input out_value, input last, output ready);
endinterface

>>> design/double_ended_queue_unit.sv
// Bounded double-ended queue of signed 32-bit values held in a ring store.
// Request channel in_ch carries req_type (push front, push back, pop front,
// pop back, list all) and push_value; result channel out_ch carries status,
// out_value and last, with a beat accepted when valid and ready are high.
// Push and pop each give one result beat with last set; a list gives one beat
// per stored entry from front to back, last set on the final one. Push on a
// full queue reports full, pop or list on an empty queue reports empty, and
// the state stays as it was. Unknown request codes give no beat.
// Timing: a request is taken in the idle state and worked on in the execute
// state, where push and error results are registered; pop results follow
// in the pop state after the synchronous store read, and a list streams one
// entry per cycle after the first read while results are taken. One request
// is in work at a time; the next is taken once the current one has loaded
// its last result, so pushes alternate the idle and execute states. The
// result register lets a new request enter while the previous one waits.
// If the receiver stalls, the result holds and the block waits. Reset empties
// the queue; store contents are not cleared and never read outside the count.
module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input logic     clk,
  input logic     rst_n,
  deq_req_if.sink   in_ch,
  deq_rsp_if.source out_ch
);
  import deq_pkg::*;

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_ch.req_type),
    .in_push_value (in_ch.push_value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_value     (out_ch.out_value),
    .out_last      (out_ch.last),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

>>> design/deq_ctrl.sv
// sequencing state machine for the double-ended queue unit
module deq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_cmd_t  cmd
);
  import deq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (stat.req)
          REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (stat.out_free) state_nxt = S_IDLE;
          end
          REQ_POP_FRONT, REQ_POP_BACK: begin
            if (!stat.empty) state_nxt = S_POP;
            else if (stat.out_free) state_nxt = S_IDLE;
          end
          REQ_LIST: begin
            if (!stat.empty) state_nxt = S_LIST;
            else if (stat.out_free) state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_POP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_LIST: begin
        if (stat.out_free && stat.list_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_EXEC: begin
        case (stat.req)
          REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (stat.out_free) begin
              cmd.out_load    = 1'b1;
              cmd.out_last    = 1'b1;
              cmd.out_status  = stat.full ? ST_FULL : ST_OK;
              cmd.commit_push = !stat.full;
            end
          end
          REQ_POP_FRONT, REQ_POP_BACK, REQ_LIST: begin
            if (stat.empty) begin
              cmd.out_load   = stat.out_free;
              cmd.out_last   = 1'b1;
              cmd.out_status = ST_EMPTY;
            end else if (stat.req == REQ_LIST) begin
              cmd.rd_first = 1'b1;
            end else begin
              cmd.rd_pop = 1'b1;
            end
          end
          default: cmd = '0;
        endcase
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_last     = 1'b1;
          cmd.commit_pop   = 1'b1;
        end
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_last     = stat.list_last;
          cmd.rd_next      = !stat.list_last;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/deq_dpath.sv
// ring store, pointers and result register of the double-ended queue unit
module deq_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_req_type,
  input  logic signed [31:0]  in_push_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_value,
  output logic                out_last,
  input  deq_pkg::deq_cmd_t   cmd,
  output deq_pkg::deq_stat_t  stat
);
  import deq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_S  = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [REQ_W-1:0]    req_r;
  logic [DATA_W-1:0]   val_r;
  logic [IW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [DATA_W-1:0]   rd_data_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]   out_value_r;
  logic                out_last_r;

  logic          out_free;
  logic          front_side;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;

  // (base + off) mod DEPTH, off below DEPTH
  function automatic logic [IW-1:0] ring_add(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + {1'b0, off};
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[IW-1:0];
  endfunction

  assign out_free   = !out_valid_r || out_ready;
  assign front_side = (req_r == REQ_PUSH_FRONT) || (req_r == REQ_POP_FRONT);
  assign front_dec  = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_inc  = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
  assign wr_addr    = front_side ? front_dec : ring_add(front_r, count_r);
  assign rd_en      = cmd.rd_pop || cmd.rd_first || cmd.rd_next;

  always_comb begin
    rd_addr = front_r;
    if (cmd.rd_pop && !front_side) begin
      rd_addr = ring_add(front_r, count_r - 1'b1);
    end else if (cmd.rd_next) begin
      rd_addr = ring_add(front_r, CW'(idx_nxt));
    end
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (cmd.commit_push) begin
      count_nxt = count_r + 1'b1;
      if (front_side) front_nxt = front_dec;
    end
    if (cmd.commit_pop) begin
      count_nxt = count_r - 1'b1;
      if (front_side) front_nxt = front_inc;
    end
    if (cmd.rd_first) idx_nxt = '0;
    if (cmd.rd_next)  idx_nxt = idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_push) mem[wr_addr] <= val_r;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req_type;
      val_r <= in_push_value;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_value_r  <= cmd.out_from_mem ? rd_data_r : '0;
      out_last_r   <= cmd.out_last;
    end
  end

  assign stat.req       = req_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == DEPTH_C);
  assign stat.list_last = ((CW'(idx_r) + 1'b1) == count_r);
  assign stat.out_free  = out_free;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  // the entry count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count beyond depth");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten");

  // a push is only committed with room left
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_push |-> (count_r != DEPTH_C))
    else $error("push committed on full store");

  // a committed pop removes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_pop |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not remove one entry");

endmodule
